/* sv/usmg_pkg.sv */
// usmg_pkg: widths, status codes, register indexes and sine coefficients
// for the UV-sphere mesh generator. No dependencies.
package usmg_pkg;

   // request and response field widths
   localparam int N_W   = 18;  // item number
   localparam int POS_W = 17;  // signed position, 1/256 units
   localparam int C_W   = 17;  // corner vertex index
   localparam int ST_W  = 2;

   // configuration
   localparam int RAD_W      = 16;
   localparam int CNT_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_RADIUS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RINGS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SECTORS = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_RESET  = 16'd256;
   localparam logic [CNT_W-1:0] RINGS_RESET   = 9'd16;
   localparam logic [CNT_W-1:0] SECTORS_RESET = 9'd16;

   localparam int MAX_RINGS   = 256;
   localparam int MAX_SECTORS = 256;

   // mesh index arithmetic (vertex count, 2 * vertex count)
   localparam int IDX_W = 20;

   // angles are fractions of a turn
   localparam int PH_W = 16;
   localparam logic [PH_W-1:0] QUARTER_TURN = 16'h4000;

   // quarter-wave sine polynomial, Q15
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [15:0] SIN_C = 16'd2320;

   // response status
   localparam logic [ST_W-1:0] ST_VALID = 2'd0;
   localparam logic [ST_W-1:0] ST_PAD   = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

/* sv/usmg_ifs.sv */
// usmg_req_if / usmg_rsp_if: valid/ready channels of the mesh generator.
// Depends on usmg_pkg for field widths.
interface usmg_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [usmg_pkg::N_W-1:0]   item_number;

   modport source (output valid, output op, output item_number, input ready);
   modport sink   (input valid, input op, input item_number, output ready);
endinterface

interface usmg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [usmg_pkg::POS_W-1:0] pos_x;
   logic signed [usmg_pkg::POS_W-1:0] pos_y;
   logic signed [usmg_pkg::POS_W-1:0] pos_z;
   logic [usmg_pkg::C_W-1:0]          corner_a;
   logic [usmg_pkg::C_W-1:0]          corner_b;
   logic [usmg_pkg::C_W-1:0]          corner_c;
   logic [usmg_pkg::ST_W-1:0]         status;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output corner_a, output corner_b, output corner_c,
                   output status, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input corner_a, input corner_b, input corner_c,
                   input status, output ready);
endinterface

/* sv/usmg_divider.sv */
// usmg_divider: pipelined restoring divider, one quotient bit per stage.
// Computes ({in_hi, in_lo}) / in_d with in_hi < in_d; no package dependency.
module usmg_divider #(
   parameter int LO_W  = 18,
   parameter int D_W   = 10,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [D_W-1:0]   in_hi,
   input  logic [LO_W-1:0]  in_lo,
   input  logic [D_W-1:0]   in_d,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [LO_W-1:0]  out_q,
   output logic [D_W-1:0]   out_r,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [LO_W];
   logic [D_W-1:0]   rem_ff   [LO_W];
   logic [LO_W-1:0]  bits_ff  [LO_W];  // remaining dividend bits, quotient shifts in
   logic [D_W-1:0]   d_ff     [LO_W];
   logic [TAG_W-1:0] tag_ff   [LO_W];

   for (genvar i = 0; i < LO_W; i++) begin : g_stage
      logic             src_valid;
      logic [D_W-1:0]   src_rem;
      logic [LO_W-1:0]  src_bits;
      logic [D_W-1:0]   src_d;
      logic [TAG_W-1:0] src_tag;
      logic [D_W:0]     trial;
      logic             ge;
      logic [D_W-1:0]   rem_in;
      logic [LO_W-1:0]  bits_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_hi;
         assign src_bits  = in_lo;
         assign src_d     = in_d;
         assign src_tag   = in_tag;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_bits  = bits_ff[i-1];
         assign src_d     = d_ff[i-1];
         assign src_tag   = tag_ff[i-1];
      end

      assign trial   = {src_rem, src_bits[LO_W-1]};
      assign ge      = trial >= {1'b0, src_d};
      assign rem_in  = ge ? D_W'(trial - {1'b0, src_d}) : trial[D_W-1:0];
      assign bits_in = {src_bits[LO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            bits_ff[i] <= bits_in;
            d_ff[i]    <= src_d;
            tag_ff[i]  <= src_tag;
         end
      end
   end

   assign out_valid = valid_ff[LO_W-1];
   assign out_q     = bits_ff[LO_W-1];
   assign out_r     = rem_ff[LO_W-1];
   assign out_tag   = tag_ff[LO_W-1];

endmodule

/* sv/uv_sphere_mesh_generator.sv */
// uv_sphere_mesh_generator: UV-sphere vertex and triangle lookup pipeline.
// Depends on usmg_pkg, usmg_ifs (channels) and usmg_divider.
//
//   channel   dir   handshake        payload
//   req       in    valid/ready      op, item_number
//   rsp       out   valid/ready      pos_x/y/z, corner_a/b/c, status
//   csr       in    csr_we           csr_index, csr_wdata
//
// One request per cycle while the response is not stalled; a request passes the
// request register, classify register, index divider (18 stages), corner register,
// angle dividers (16 stages), six sine and scaling stages and the output register.
// Synchronous reset restores the registers to radius 256, 16 rings, 16 sectors.
// A stalled response freezes the whole pipeline; req.ready follows it.
module uv_sphere_mesh_generator (
   input  logic                               clock,
   input  logic                               reset,
   usmg_req_if.sink                           req,
   usmg_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [usmg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [usmg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int N_W   = usmg_pkg::N_W;
   localparam int CNT_W = usmg_pkg::CNT_W;
   localparam int D_W   = CNT_W + 1;
   localparam int IDX_W = usmg_pkg::IDX_W;
   localparam int C_W   = usmg_pkg::C_W;
   localparam int POS_W = usmg_pkg::POS_W;
   localparam int RAD_W = usmg_pkg::RAD_W;
   localparam int PH_W  = usmg_pkg::PH_W;
   localparam int ST_W  = usmg_pkg::ST_W;
   localparam int TAILS = 6;   // stages between angle dividers and output
   localparam int LANES = 4;

   localparam int L_S1 = 0;   // sin of latitude
   localparam int L_C1 = 1;   // cos of latitude
   localparam int L_S2 = 2;   // sin of longitude
   localparam int L_C2 = 3;   // cos of longitude

   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] K_NONE     = 3'd0;
   localparam logic [KIND_W-1:0] K_RING     = 3'd1;
   localparam logic [KIND_W-1:0] K_TOP_POLE = 3'd2;
   localparam logic [KIND_W-1:0] K_BOT_POLE = 3'd3;
   localparam logic [KIND_W-1:0] K_TOP_CAP  = 3'd4;
   localparam logic [KIND_W-1:0] K_MID      = 3'd5;
   localparam logic [KIND_W-1:0] K_BOT_CAP  = 3'd6;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ST_W-1:0]   st;
      logic              odd;
      logic [N_W-1:0]    n;
      logic [IDX_W-1:0]  bot_b;
   } idx_tag_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ST_W-1:0]   st;
      logic [C_W-1:0]    ca;
      logic [C_W-1:0]    cb;
      logic [C_W-1:0]    cc;
   } ang_tag_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input int maxv);
      logic [CNT_W+2:0] vw;
      vw = (CNT_W+3)'(v);
      if (v == '0) begin
         return CNT_W'(1);
      end else if (vw > (CNT_W+3)'(maxv)) begin
         return CNT_W'(maxv);
      end
      return v;
   endfunction

   // ---------------- configuration and derived mesh sizes ----------------
   logic [RAD_W-1:0] radius_ff, radius_in;
   logic [CNT_W-1:0] rings_raw_ff, rings_raw_in;
   logic [CNT_W-1:0] sectors_raw_ff, sectors_raw_in;

   always_comb begin
      radius_in      = radius_ff;
      rings_raw_in   = rings_raw_ff;
      sectors_raw_in = sectors_raw_ff;
      if (reset) begin
         radius_in      = usmg_pkg::RADIUS_RESET;
         rings_raw_in   = usmg_pkg::RINGS_RESET;
         sectors_raw_in = usmg_pkg::SECTORS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            usmg_pkg::REG_RADIUS:  radius_in      = csr_wdata[RAD_W-1:0];
            usmg_pkg::REG_RINGS:   rings_raw_in   = csr_wdata[CNT_W-1:0];
            usmg_pkg::REG_SECTORS: sectors_raw_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      radius_ff      <= radius_in;
      rings_raw_ff   <= rings_raw_in;
      sectors_raw_ff <= sectors_raw_in;
   end

   // derived values track the next register contents, so they are current
   // from the first cycle after a write
   logic [CNT_W-1:0]   rings_in, segs_in, segs_ff;
   logic [D_W-1:0]     seg1_in, ring1_in, seg1_ff, ring1_ff;
   logic [2*CNT_W:0]   nv_prod;
   logic [2*CNT_W-1:0] rs_prod;
   logic [IDX_W-1:0]   nv_in, ntri_in, mid_end_in, two_nv_in, nv_mid_in;
   logic [IDX_W-1:0]   nv_ff, ntri_ff, mid_end_ff, two_nv_ff, nv_mid_ff;

   always_comb begin
      rings_in   = clamp_count(rings_raw_in, usmg_pkg::MAX_RINGS);
      segs_in    = clamp_count(sectors_raw_in, usmg_pkg::MAX_SECTORS);
      seg1_in    = {1'b0, segs_in} + D_W'(1);
      ring1_in   = {1'b0, rings_in} + D_W'(1);
      nv_prod    = seg1_in * rings_in;
      rs_prod    = rings_in * segs_in;
      nv_in      = IDX_W'(nv_prod) + IDX_W'(2);
      ntri_in    = IDX_W'({rs_prod, 1'b0});
      mid_end_in = ntri_in - IDX_W'(segs_in);
      two_nv_in  = {nv_in[IDX_W-2:0], 1'b0};
      nv_mid_in  = nv_in + mid_end_in - IDX_W'(3);
   end

   always_ff @(posedge clock) begin
      segs_ff    <= segs_in;
      seg1_ff    <= seg1_in;
      ring1_ff   <= ring1_in;
      nv_ff      <= nv_in;
      ntri_ff    <= ntri_in;
      mid_end_ff <= mid_end_in;
      two_nv_ff  <= two_nv_in;
      nv_mid_ff  <= nv_mid_in;
   end

   // ---------------- flow control ----------------
   logic out_v_ff, out_v_in;
   logic adv;
   logic acc;

   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv && !reset;
   assign acc       = req.valid && req.ready;

   // ---------------- S0: request register ----------------
   logic           v0_ff;
   logic           op0_ff;
   logic [N_W-1:0] n0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op0_ff <= req.op;
         n0_ff  <= req.item_number;
      end
   end

   // ---------------- S1: classify, set up index division ----------------
   logic          v1_ff;
   idx_tag_type    tag1_ff, tag1_in;
   logic [N_W-1:0] lo1_ff, lo1_in;
   logic [D_W-1:0] d1_ff, d1_in;
   logic [IDX_W-1:0] n_x;
   logic [N_W-1:0]   tri_m;

   always_comb begin
      n_x           = IDX_W'(n0_ff);
      tri_m         = n0_ff - N_W'(segs_ff);
      tag1_in       = '0;
      tag1_in.n     = n0_ff;
      tag1_in.odd   = tri_m[0];
      tag1_in.bot_b = nv_mid_ff - n_x;
      tag1_in.st    = usmg_pkg::ST_VALID;
      tag1_in.kind  = K_NONE;
      if (!op0_ff) begin
         if (n_x >= nv_ff) begin
            tag1_in.st = usmg_pkg::ST_RANGE;
         end else if (n_x == '0) begin
            tag1_in.kind = K_TOP_POLE;
         end else if (n_x == nv_ff - IDX_W'(1)) begin
            tag1_in.kind = K_BOT_POLE;
         end else begin
            tag1_in.kind = K_RING;
         end
      end else begin
         if (n_x < IDX_W'(segs_ff)) begin
            tag1_in.kind = K_TOP_CAP;
         end else if (n_x < mid_end_ff) begin
            tag1_in.kind = K_MID;
         end else if (n_x < ntri_ff) begin
            tag1_in.kind = K_BOT_CAP;
         end else if (n_x < two_nv_ff) begin
            tag1_in.st = usmg_pkg::ST_PAD;
         end else begin
            tag1_in.st = usmg_pkg::ST_RANGE;
         end
      end
      // ring point: (n-1) / (segs+1); quad: ((n-segs) >> 1) / segs
      lo1_in = op0_ff ? {1'b0, tri_m[N_W-1:1]} : n0_ff - N_W'(1);
      d1_in  = op0_ff ? {1'b0, segs_ff} : seg1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff <= tag1_in;
         lo1_ff  <= lo1_in;
         d1_ff   <= d1_in;
      end
   end

   logic           v_d1;
   logic [N_W-1:0] q_d1;
   logic [D_W-1:0] r_d1;
   idx_tag_type    tag_d1;

   usmg_divider #(
      .LO_W  (N_W),
      .D_W   (D_W),
      .TAG_W ($bits(idx_tag_type))
   ) u_div_idx (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v1_ff),
      .in_hi     ('0),
      .in_lo     (lo1_ff),
      .in_d      (d1_ff),
      .in_tag    (tag1_ff),
      .out_valid (v_d1),
      .out_q     (q_d1),
      .out_r     (r_d1),
      .out_tag   (tag_d1)
   );

   // ---------------- S2: triangle corners, angle dividends ----------------
   logic              v2_ff;
   ang_tag_type       tag2_ff, tag2_in;
   logic [D_W-1:0]    a1_ff, a1_in, a2_ff, a2_in;
   logic [N_W+D_W-1:0] cur_prod;
   logic [IDX_W-1:0]  cur, nxt, nxt1;

   always_comb begin
      cur_prod     = q_d1 * seg1_ff;
      cur          = cur_prod[IDX_W-1:0] + IDX_W'(r_d1) + IDX_W'(1);
      nxt          = cur + IDX_W'(seg1_ff);
      nxt1         = nxt + IDX_W'(1);
      tag2_in      = '0;
      tag2_in.kind = tag_d1.kind;
      tag2_in.st   = tag_d1.st;
      case (tag_d1.kind)
         K_TOP_CAP: begin
            tag2_in.ca = C_W'(tag_d1.n + N_W'(2));
            tag2_in.cb = C_W'(tag_d1.n + N_W'(1));
         end
         K_MID: begin
            tag2_in.ca = C_W'(cur);
            if (tag_d1.odd) begin
               tag2_in.cb = C_W'(nxt1);
               tag2_in.cc = C_W'(nxt);
            end else begin
               tag2_in.cb = C_W'(cur + IDX_W'(1));
               tag2_in.cc = C_W'(nxt1);
            end
         end
         K_BOT_CAP: begin
            tag2_in.ca = C_W'(nv_ff - IDX_W'(1));
            tag2_in.cb = C_W'(tag_d1.bot_b);
            tag2_in.cc = C_W'(tag_d1.bot_b + IDX_W'(1));
         end
         default: ;
      endcase
      a1_in = q_d1[D_W-1:0] + D_W'(1);
      // seam column repeats longitude 0
      a2_in = (r_d1 == {1'b0, segs_ff}) ? '0 : r_d1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v_d1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag2_ff <= tag2_in;
         a1_ff   <= a1_in;
         a2_ff   <= a2_in;
      end
   end

   logic            v_d2;
   ang_tag_type     tag_d2;
   logic [PH_W-1:0] ph1_q, ph2_q;

   // latitude phase is taken at 16 bits and halved
   usmg_divider #(
      .LO_W  (PH_W),
      .D_W   (D_W),
      .TAG_W ($bits(ang_tag_type))
   ) u_div_lat (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v2_ff),
      .in_hi     (a1_ff),
      .in_lo     ('0),
      .in_d      (ring1_ff),
      .in_tag    (tag2_ff),
      .out_valid (v_d2),
      .out_q     (ph1_q),
      .out_r     (),
      .out_tag   (tag_d2)
   );

   usmg_divider #(
      .LO_W  (PH_W),
      .D_W   (D_W),
      .TAG_W (1)
   ) u_div_lon (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (1'b0),
      .in_hi     (a2_ff),
      .in_lo     ('0),
      .in_d      ({1'b0, segs_ff}),
      .in_tag    (1'b0),
      .out_valid (),
      .out_q     (ph2_q),
      .out_r     (),
      .out_tag   ()
   );

   // ---------------- S3..S8: sine lanes and scaling ----------------
   logic        vp_ff  [TAILS];
   ang_tag_type tagp_ff[TAILS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAILS; i++) begin
            vp_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vp_ff[0] <= v_d2;
         for (int i = 1; i < TAILS; i++) begin
            vp_ff[i] <= vp_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tagp_ff[0] <= tag_d2;
         for (int i = 1; i < TAILS; i++) begin
            tagp_ff[i] <= tagp_ff[i-1];
         end
      end
   end

   logic [PH_W-1:0] ph    [LANES];
   logic [14:0]     z_in  [LANES];
   logic [29:0]     zz    [LANES];
   logic [14:0]     z2_in [LANES];
   logic [14:0]     z3_ff [LANES], z23_ff[LANES];
   logic            neg3_ff[LANES];

   always_comb begin
      ph[L_S1] = {1'b0, ph1_q[PH_W-1:1]};
      ph[L_C1] = {1'b0, ph1_q[PH_W-1:1]} + usmg_pkg::QUARTER_TURN;
      ph[L_S2] = ph2_q;
      ph[L_C2] = ph2_q + usmg_pkg::QUARTER_TURN;
      for (int l = 0; l < LANES; l++) begin
         // odd quadrants mirror the quarter wave
         z_in[l]  = ph[l][14] ? 15'(15'h4000 - {1'b0, ph[l][13:0]})
                              : {1'b0, ph[l][13:0]};
         zz[l]    = z_in[l] * z_in[l];
         z2_in[l] = zz[l][28:14];
      end
   end

   logic [30:0] cz    [LANES];
   logic [14:0] t1_in [LANES];
   logic [14:0] z4_ff [LANES], z24_ff[LANES], t14_ff[LANES];
   logic        neg4_ff[LANES];

   logic [29:0] tz    [LANES];
   logic [15:0] t2_in [LANES];
   logic [14:0] z5_ff [LANES];
   logic [15:0] t25_ff[LANES];
   logic        neg5_ff[LANES];

   logic [30:0] mz    [LANES];
   logic [15:0] m6_ff [LANES];
   logic        neg6_ff[LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cz[l]    = 31'(usmg_pkg::SIN_C) * 31'(z23_ff[l]);
         t1_in[l] = 15'(usmg_pkg::SIN_B - cz[l][29:14]);
         tz[l]    = t14_ff[l] * z24_ff[l];
         t2_in[l] = usmg_pkg::SIN_A - tz[l][29:14];
         mz[l]    = t25_ff[l] * z5_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            z3_ff[l]   <= z_in[l];
            z23_ff[l]  <= z2_in[l];
            neg3_ff[l] <= ph[l][15];
            z4_ff[l]   <= z3_ff[l];
            z24_ff[l]  <= z23_ff[l];
            t14_ff[l]  <= t1_in[l];
            neg4_ff[l] <= neg3_ff[l];
            z5_ff[l]   <= z4_ff[l];
            t25_ff[l]  <= t2_in[l];
            neg5_ff[l] <= neg4_ff[l];
            m6_ff[l]   <= mz[l][29:14];
            neg6_ff[l] <= neg5_ff[l];
         end
      end
   end

   // S7: magnitudes of sin1*cos2, sin1*sin2 and cos1*R
   logic [31:0] pxm7_ff, pzm7_ff, pym7_ff;
   logic        sx7_ff, sz7_ff, sy7_ff;
   // S8: scaled by R, y rounded
   logic [47:0] pxp8_ff, pzp8_ff;
   logic [17:0] py8_ff;
   logic        sx8_ff, sz8_ff, sy8_ff;
   logic [32:0] pyr;

   assign pyr = {1'b0, pym7_ff} + 33'h4000;

   always_ff @(posedge clock) begin
      if (adv) begin
         pxm7_ff <= m6_ff[L_S1] * m6_ff[L_C2];
         pzm7_ff <= m6_ff[L_S1] * m6_ff[L_S2];
         pym7_ff <= m6_ff[L_C1] * radius_ff;
         sx7_ff  <= neg6_ff[L_S1] ^ neg6_ff[L_C2];
         sz7_ff  <= neg6_ff[L_S1] ^ neg6_ff[L_S2];
         sy7_ff  <= neg6_ff[L_C1];
         pxp8_ff <= pxm7_ff * radius_ff;
         pzp8_ff <= pzm7_ff * radius_ff;
         py8_ff  <= pyr[32:15];
         sx8_ff  <= sx7_ff;
         sz8_ff  <= sz7_ff;
         sy8_ff  <= sy7_ff;
      end
   end

   // ---------------- S9: output register ----------------
   logic [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [C_W-1:0]   ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic [ST_W-1:0]  st_ff, st_in;
   logic [47:0]      pxr, pzr;
   logic [POS_W-1:0] x_mag, y_mag, z_mag, r17;
   ang_tag_type      t8;

   always_comb begin
      t8       = tagp_ff[TAILS-1];
      pxr      = pxp8_ff + 48'h2000_0000;
      pzr      = pzp8_ff + 48'h2000_0000;
      x_mag    = POS_W'(pxr[47:30]);
      z_mag    = POS_W'(pzr[47:30]);
      y_mag    = POS_W'(py8_ff);
      r17      = {1'b0, radius_ff};
      pos_x_in = '0;
      pos_y_in = '0;
      pos_z_in = '0;
      ca_in    = '0;
      cb_in    = '0;
      cc_in    = '0;
      st_in    = t8.st;
      case (t8.kind)
         K_RING: begin
            pos_x_in = sx8_ff ? (~x_mag + POS_W'(1)) : x_mag;
            pos_y_in = sy8_ff ? (~y_mag + POS_W'(1)) : y_mag;
            pos_z_in = sz8_ff ? (~z_mag + POS_W'(1)) : z_mag;
         end
         K_TOP_POLE: pos_y_in = r17;
         K_BOT_POLE: pos_y_in = ~r17 + POS_W'(1);
         K_TOP_CAP, K_MID, K_BOT_CAP: begin
            ca_in = t8.ca;
            cb_in = t8.cb;
            cc_in = t8.cc;
         end
         default: ;
      endcase
      out_v_in = adv ? vp_ff[TAILS-1] : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
         cc_ff    <= cc_in;
         st_ff    <= st_in;
      end
   end

   assign rsp.valid    = out_v_ff;
   assign rsp.pos_x    = pos_x_ff;
   assign rsp.pos_y    = pos_y_ff;
   assign rsp.pos_z    = pos_z_ff;
   assign rsp.corner_a = ca_ff;
   assign rsp.corner_b = cb_ff;
   assign rsp.corner_c = cc_ff;
   assign rsp.status   = st_ff;

   // ---------------- checks ----------------
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == usmg_pkg::ST_RANGE |->
         rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.pos_z == '0 &&
         rsp.corner_a == '0 && rsp.corner_b == '0 && rsp.corner_c == '0)
      else $error("out-of-range response carries data");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == usmg_pkg::ST_PAD |->
         rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.pos_z == '0 &&
         rsp.corner_a == '0 && rsp.corner_b == '0 && rsp.corner_c == '0)
      else $error("padding triangle is not all zero");

   a_tri_no_pos: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.corner_a != '0 || rsp.corner_b != '0) |->
         rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.pos_z == '0)
      else $error("triangle response carries a position");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status == usmg_pkg::ST_VALID ||
                    rsp.status == usmg_pkg::ST_PAD ||
                    rsp.status == usmg_pkg::ST_RANGE)
      else $error("unknown status code");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request taken while the pipeline is stalled");

endmodule

/* verif/tb_uv_sphere_mesh_generator.sv */
// Testbench for the UV-sphere mesh generator: directed table plus random
// vertex and triangle requests, checked against an in-bench mesh predictor.
// Depends on usmg_pkg, usmg_ifs and the uv_sphere_mesh_generator RTL.
`timescale 1ns / 1ps

module tb_uv_sphere_mesh_generator;

   localparam int N_W        = usmg_pkg::N_W;
   localparam int POS_W      = usmg_pkg::POS_W;
   localparam int C_W        = usmg_pkg::C_W;
   localparam int ST_W       = usmg_pkg::ST_W;
   localparam int CSR_IDX_W  = usmg_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = usmg_pkg::CSR_DATA_W;
   localparam int MAX_RINGS   = usmg_pkg::MAX_RINGS;
   localparam int MAX_SECTORS = usmg_pkg::MAX_SECTORS;
   localparam logic [15:0] SIN_A = usmg_pkg::SIN_A;
   localparam logic [15:0] SIN_B = usmg_pkg::SIN_B;
   localparam logic [15:0] SIN_C = usmg_pkg::SIN_C;
   localparam logic [15:0] QUARTER_TURN = usmg_pkg::QUARTER_TURN;
   localparam logic [ST_W-1:0] ST_VALID = usmg_pkg::ST_VALID;
   localparam logic [ST_W-1:0] ST_PAD   = usmg_pkg::ST_PAD;
   localparam logic [ST_W-1:0] ST_RANGE = usmg_pkg::ST_RANGE;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS  = usmg_pkg::REG_RADIUS;
   localparam logic [CSR_IDX_W-1:0] REG_RINGS   = usmg_pkg::REG_RINGS;
   localparam logic [CSR_IDX_W-1:0] REG_SECTORS = usmg_pkg::REG_SECTORS;
   // index past the register list, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 2'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] px, py, pz;
      logic [C_W-1:0]          ca, cb, cc;
      logic [ST_W-1:0]         st;
   } mesh_rsp_type;

   typedef struct {
      logic           op;
      int unsigned    num;
      bit             has_exp;
      mesh_rsp_type   exp;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   usmg_req_if req ();
   usmg_rsp_if rsp ();

   uv_sphere_mesh_generator uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow configuration
   int unsigned  radius_sh, rings_sh, sectors_sh;
   mesh_rsp_type expected_rsps[$];
   int           mismatches = 0;
   bit           hold_rsp = 0;
   bit           long_hold = 0;
   dir_row_type  rows[$];

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned clamp_cnt(int unsigned v, int unsigned mx);
      if (v < 1) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   function automatic longint unsigned qsin(longint unsigned z);
      longint unsigned z2, t;
      z2 = (z * z) >> 14;
      t = (SIN_C * z2) >> 14;
      t = SIN_B - t;
      t = (t * z2) >> 14;
      t = SIN_A - t;
      return (t * z) >> 14;
   endfunction

   function automatic longint turn_sine(logic [15:0] p);
      logic [1:0] q;
      longint unsigned f, m;
      q = p[15:14];
      f = p[13:0];
      m = q[0] ? qsin(16384 - f) : qsin(f);
      return q[1] ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [POS_W-1:0] round_sh(longint num, int sh);
      longint unsigned mag, r;
      mag = (num < 0) ? longint'(-num) : num;
      r = (mag + (64'd1 << (sh - 1))) >> sh;
      return (num < 0) ? POS_W'(-r) : POS_W'(r);
   endfunction

   function automatic mesh_rsp_type predict_mesh(logic op, int unsigned n);
      mesh_rsp_type o;
      longint unsigned rings, segs, nv, k, lat, lon, ph1, ph2, mid, ntri, m, quad, cur, nxt;
      longint s1, c1, s2, c2, r;
      o = '0;
      rings = clamp_cnt(rings_sh, MAX_RINGS);
      segs = clamp_cnt(sectors_sh, MAX_SECTORS);
      nv = (segs + 1) * rings + 2;
      r = radius_sh;
      if (op == 1'b0) begin
         if (n >= nv) o.st = ST_RANGE;
         else if (n == 0) o.py = POS_W'(r);
         else if (n == nv - 1) o.py = POS_W'(-r);
         else begin
            k = n - 1;
            lat = k / (segs + 1);
            lon = k % (segs + 1);
            ph1 = ((lat + 1) << 15) / (rings + 1);
            ph2 = (lon == segs) ? 0 : ((lon << 16) / segs);
            s1 = turn_sine(ph1[15:0]);
            c1 = turn_sine(ph1[15:0] + QUARTER_TURN);
            s2 = turn_sine(ph2[15:0]);
            c2 = turn_sine(ph2[15:0] + QUARTER_TURN);
            o.px = round_sh(s1 * c2 * r, 30);
            o.py = round_sh(c1 * r, 15);
            o.pz = round_sh(s1 * s2 * r, 30);
         end
      end else begin
         mid = 2 * (rings - 1) * segs;
         ntri = 2 * rings * segs;
         if (n < segs) begin
            o.ca = C_W'(n + 2); o.cb = C_W'(n + 1); o.cc = '0;
         end else if (n < segs + mid) begin
            m = n - segs;
            quad = m >> 1;
            lat = quad / segs;
            lon = quad % segs;
            cur = lon + lat * (segs + 1) + 1;
            nxt = cur + segs + 1;
            o.ca = C_W'(cur);
            if (m[0] == 0) begin
               o.cb = C_W'(cur + 1); o.cc = C_W'(nxt + 1);
            end else begin
               o.cb = C_W'(nxt + 1); o.cc = C_W'(nxt);
            end
         end else if (n < ntri) begin
            lon = n - segs - mid;
            o.ca = C_W'(nv - 1); o.cb = C_W'(nv - lon - 3); o.cc = C_W'(nv - lon - 2);
         end else if (n < 2 * nv) o.st = ST_PAD;
         else o.st = ST_RANGE;
      end
      return o;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_RADIUS:  radius_sh = val & 16'hFFFF;
         REG_RINGS:   rings_sh = val & 9'h1FF;
         REG_SECTORS: sectors_sh = val & 9'h1FF;
         default: ;
      endcase
   endtask

   // valid stays high into the next request when there is no gap
   task automatic send_req(logic op, int unsigned n);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.op <= op;
      req.item_number <= N_W'(n);
      do @(posedge clock); while (!req.ready);
      expected_rsps.push_back(predict_mesh(op, n));
   endtask

   // drain, then wait past the pipeline latency before touching registers
   task automatic drain();
      req.valid <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_phase(int cnt);
      int unsigned rings, segs, nv, lim;
      logic op;
      rings = clamp_cnt(rings_sh, MAX_RINGS);
      segs = clamp_cnt(sectors_sh, MAX_SECTORS);
      nv = (segs + 1) * rings + 2;
      for (int i = 0; i < cnt; i++) begin
         op = $urandom_range(0, 1);
         lim = op ? 2 * nv + 4 : nv + 4;
         if ($urandom_range(0, 15) == 0) send_req(op, $urandom_range(0, 262143));
         else send_req(op, $urandom_range(0, lim));
      end
   endtask

   // response sink
   always @(posedge clock) begin
      mesh_rsp_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.corner_a, rsp.corner_b,
                 rsp.corner_c, rsp.status};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
            end
         end
      end
      if (reset || long_hold) rsp.ready <= 0;
      else if (hold_rsp) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 1) == 0);
   end

   // ready stall: random holdoffs
   initial begin
      int n;
      forever begin
         n = $urandom_range(0, 7);
         hold_rsp = 1;
         repeat (n) @(posedge clock);
         hold_rsp = 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req.valid = 0;
      req.op = 0;
      req.item_number = '0;
      radius_sh = usmg_pkg::RADIUS_RESET;
      rings_sh = usmg_pkg::RINGS_RESET;
      sectors_sh = usmg_pkg::SECTORS_RESET;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: reset geometry, poles, range edges, caps, padding
      rows.push_back('{0, 0, 1, '{0, 256, 0, 0, 0, 0, ST_VALID}});
      rows.push_back('{0, 273, 1, '{0, -256, 0, 0, 0, 0, ST_VALID}});
      rows.push_back('{0, 274, 1, '{0, 0, 0, 0, 0, 0, ST_RANGE}});
      rows.push_back('{0, 262143, 1, '{0, 0, 0, 0, 0, 0, ST_RANGE}});
      rows.push_back('{1, 0, 1, '{0, 0, 0, 2, 1, 0, ST_VALID}});
      rows.push_back('{1, 512, 1, '{0, 0, 0, 0, 0, 0, ST_PAD}});
      rows.push_back('{1, 547, 1, '{0, 0, 0, 0, 0, 0, ST_PAD}});
      rows.push_back('{1, 548, 1, '{0, 0, 0, 0, 0, 0, ST_RANGE}});
      rows.push_back('{1, 262143, 1, '{0, 0, 0, 0, 0, 0, ST_RANGE}});
      rows.push_back('{0, 1, 0, '0});
      rows.push_back('{0, 16, 0, '0});
      rows.push_back('{0, 17, 0, '0});
      rows.push_back('{0, 136, 0, '0});
      rows.push_back('{1, 15, 0, '0});
      rows.push_back('{1, 16, 0, '0});
      rows.push_back('{1, 17, 0, '0});
      rows.push_back('{1, 495, 0, '0});
      rows.push_back('{1, 496, 0, '0});
      rows.push_back('{1, 511, 0, '0});
      foreach (rows[i]) begin
         send_req(rows[i].op, rows[i].num);
         if (rows[i].has_exp) expected_rsps[expected_rsps.size()-1] = rows[i].exp;
      end

      // long receiver holdoff while requests keep coming
      fork
         begin
            long_hold = 1;
            repeat (150) @(posedge clock);
            long_hold = 0;
         end
         random_phase(100);
      join
      drain();

      write_reg(REG_RADIUS, 16'hFFFF);
      write_reg(REG_RINGS, 1);
      write_reg(REG_SECTORS, 1);
      send_req(0, 0); send_req(0, 3); send_req(1, 0); send_req(1, 1);
      random_phase(150);
      drain();

      write_reg(REG_RADIUS, 0);
      write_reg(REG_RINGS, 0);
      write_reg(REG_SECTORS, 511);
      random_phase(150);
      drain();

      write_reg(REG_RADIUS, 16'hFFFF);
      write_reg(REG_RINGS, 256);
      write_reg(REG_SECTORS, 256);
      send_req(0, 66049); send_req(0, 66050); send_req(1, 131072);
      send_req(1, 131585); send_req(1, 132100); send_req(1, 132099);
      random_phase(150);
      drain();

      write_reg(REG_RINGS, 511);
      write_reg(REG_SECTORS, 0);
      write_reg(REG_UNUSED, 16'h1234);
      random_phase(150);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(REG_RADIUS, $urandom_range(0, 65535));
         write_reg(REG_RINGS, $urandom_range(1, 24));
         write_reg(REG_SECTORS, $urandom_range(1, 24));
         random_phase(160);
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
